// ----- rtl/sswbfc_pkg.sv -----
// shared types and constants for the single-sector write-back flash cache
// no dependencies; imported by single_sector_write_back_flash_cache

package sswbfc_pkg;

  // command codes
  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_FLUSH = 2'd2;
  localparam logic [1:0] CMD_NONE  = 2'd3;

  // status codes
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_RANGE     = 2'd1;
  localparam logic [1:0] STAT_BAD_UNIT  = 2'd2;

  localparam logic [7:0]  BLANK_BYTE     = 8'hFF;
  localparam logic [16:0] AREA_LIMIT_RST = 17'd65536;

  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  unit;
    logic [15:0] address;
    logic [7:0]  write_data;
    logic        last_of_transfer;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [1:0] status;
    logic       evicted;
    logic       erased;
    logic       end_of_transfer;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_READ,
    S_SCAN,
    S_WBACK,
    S_LOAD,
    S_WRITE,
    S_FIN
  } state_t;

endpackage

// ----- rtl/single_sector_write_back_flash_cache.sv -----
// one-line write-back cache of a flash erase sector, with the flash array held inside
// depends on sswbfc_pkg (transaction structs, command/status codes, sequencer states)

// A transaction is one byte access: write, read or flush. The block takes one transaction
// at a time; in_ready is high only while the sequencer is idle, and a finished result sits
// in the output register so the next transaction can be taken while it waits. With the
// result slot free, a failed access, a hit write or a clean flush passes S_CHECK and
// S_FIN only; a read adds S_READ. A write miss loads the whole sector through the single
// flash read port, one byte a cycle. If the line is dirty, the eviction first scans the
// line for a non-blank byte and then copies it back, each one byte a cycle through the
// line buffer read port, before the load of a write miss or as the body of a dirty flush.
// The flash array comes out of reset erased without a clearing pass: one written flag per
// sector makes an unwritten sector read as 0xFF. The user must write area_limit through
// cfg_we/cfg_wdata only while no transaction is open; the block does not enforce this.

module single_sector_write_back_flash_cache #(
  parameter int SECTOR_BYTES  = 4096,
  parameter int FLASH_SECTORS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  sswbfc_pkg::in_item_t  in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output sswbfc_pkg::out_item_t out_data,
  input  logic                  cfg_we,
  input  logic [16:0]           cfg_wdata
);

  import sswbfc_pkg::*;

  localparam int OFF_W       = $clog2(SECTOR_BYTES);
  localparam int TAG_W       = (FLASH_SECTORS > 1) ? $clog2(FLASH_SECTORS) : 1;
  localparam int FA_W        = TAG_W + OFF_W;
  localparam int FLASH_BYTES = SECTOR_BYTES * FLASH_SECTORS;
  localparam int CNT_W       = OFF_W + 1;
  localparam logic [CNT_W-1:0] CNT_END = CNT_W'(SECTOR_BYTES);

  // storage
  logic [7:0] lb_mem [SECTOR_BYTES];
  logic [7:0] fl_mem [FLASH_BYTES];

  // control state
  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [TAG_W-1:0]   line_sector_r;
  logic               line_valid_r;
  logic               line_dirty_r;
  logic               sec_wr_r [FLASH_SECTORS];
  logic [16:0]        area_limit_r;
  logic               out_valid_r;
  logic               blank_r;

  // payload
  in_item_t           item_r;
  out_item_t          res_r;
  out_item_t          out_data_r;
  logic [7:0]         lb_q_r;
  logic [7:0]         fl_q_r;

  // memory port controls
  logic [OFF_W-1:0]   lb_raddr, lb_waddr;
  logic               lb_we;
  logic [7:0]         lb_wdata;
  logic [FA_W-1:0]    fl_raddr, fl_waddr;
  logic               fl_we;

  // decode of the held transaction
  logic [31:0]        addr_sh;
  logic [TAG_W-1:0]   item_tag;
  logic [OFF_W-1:0]   item_off;
  logic [CNT_W-1:0]   cnt_m1;
  logic               is_access;
  logic               out_of_range;
  logic [1:0]         acc_status;
  logic               hit;
  logic               sec_fill;
  logic               out_free;

  assign addr_sh      = 32'(item_r.address) >> OFF_W;
  assign item_tag     = addr_sh[TAG_W-1:0];
  assign item_off     = item_r.address[OFF_W-1:0];
  assign cnt_m1       = cnt_r - CNT_W'(1);
  assign is_access    = (item_r.command == CMD_WRITE) || (item_r.command == CMD_READ);
  assign out_of_range = ({1'b0, item_r.address} >= area_limit_r) ||
                        (32'(item_r.address) >= 32'(FLASH_BYTES));
  assign acc_status   = out_of_range ? STAT_RANGE :
                        (item_r.unit != 8'd0) ? STAT_BAD_UNIT : STAT_OK;
  assign hit          = line_valid_r && (item_tag == line_sector_r);
  // a sector never written back still holds its erased contents
  assign sec_fill     = sec_wr_r[item_tag];
  assign out_free     = !out_valid_r || out_ready;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // sequencer: next state and memory port controls
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    lb_raddr  = item_off;
    lb_we     = 1'b0;
    lb_waddr  = item_off;
    lb_wdata  = item_r.write_data;
    fl_raddr  = {item_tag, item_off};
    fl_we     = 1'b0;
    fl_waddr  = {line_sector_r, cnt_m1[OFF_W-1:0]};
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        cnt_nxt = '0;
        if (is_access && acc_status != STAT_OK) begin
          state_nxt = S_FIN;
        end else if (item_r.command == CMD_WRITE) begin
          if (hit) begin
            lb_we     = 1'b1;
            state_nxt = S_FIN;
          end else if (line_valid_r && line_dirty_r) begin
            state_nxt = S_SCAN;
          end else begin
            state_nxt = S_LOAD;
          end
        end else if (item_r.command == CMD_READ) begin
          state_nxt = S_READ;
        end else if (item_r.command == CMD_FLUSH && line_valid_r && line_dirty_r) begin
          state_nxt = S_SCAN;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_READ: begin
        state_nxt = S_FIN;
      end
      S_SCAN: begin
        // read one line byte a cycle; the compare works on the registered read data
        lb_raddr = cnt_r[OFF_W-1:0];
        if (cnt_r == CNT_END) begin
          cnt_nxt   = '0;
          state_nxt = S_WBACK;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      S_WBACK: begin
        lb_raddr = cnt_r[OFF_W-1:0];
        fl_we    = (cnt_r != '0);
        if (cnt_r == CNT_END) begin
          cnt_nxt   = '0;
          state_nxt = (item_r.command == CMD_WRITE) ? S_LOAD : S_FIN;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      S_LOAD: begin
        fl_raddr = {item_tag, cnt_r[OFF_W-1:0]};
        lb_we    = (cnt_r != '0);
        lb_waddr = cnt_m1[OFF_W-1:0];
        lb_wdata = sec_fill ? fl_q_r : BLANK_BYTE;
        if (cnt_r == CNT_END) begin
          cnt_nxt   = '0;
          state_nxt = S_WRITE;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      S_WRITE: begin
        // merge the written byte into the freshly loaded line
        lb_we     = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // line buffer: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (lb_we) begin
      lb_mem[lb_waddr] <= lb_wdata;
    end
    lb_q_r <= lb_mem[lb_raddr];
  end

  // flash array: programming is a plain overwrite of the whole sector
  always_ff @(posedge clk) begin
    if (fl_we) begin
      fl_mem[fl_waddr] <= lb_q_r;
    end
    fl_q_r <= fl_mem[fl_raddr];
  end

  // line tag, flags, config and result handling
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_sector_r <= '0;
      line_valid_r  <= 1'b0;
      line_dirty_r  <= 1'b0;
      area_limit_r  <= AREA_LIMIT_RST;
      out_valid_r   <= 1'b0;
      blank_r       <= 1'b1;
      for (int i = 0; i < FLASH_SECTORS; i++) begin
        sec_wr_r[i] <= 1'b0;
      end
    end else begin
      if (cfg_we) begin
        area_limit_r <= cfg_wdata;
      end
      // result slot: load a finished result, else free it once taken
      if (state_r == S_FIN && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_CHECK: begin
          blank_r <= 1'b1;
          if (!(is_access && acc_status != STAT_OK) &&
              item_r.command == CMD_WRITE && hit) begin
            line_dirty_r <= 1'b1;
          end
        end
        S_SCAN: begin
          if (cnt_r != '0 && lb_q_r != BLANK_BYTE) begin
            blank_r <= 1'b0;
          end
        end
        S_WBACK: begin
          if (cnt_r == CNT_END) begin
            sec_wr_r[line_sector_r] <= 1'b1;
            line_dirty_r            <= 1'b0;
          end
        end
        S_LOAD: begin
          if (cnt_r == CNT_END) begin
            line_sector_r <= item_tag;
            line_valid_r  <= 1'b1;
          end
        end
        S_WRITE: begin
          line_dirty_r <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // transaction and result payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_data;
    end
    case (state_r)
      S_CHECK: begin
        res_r.read_data       <= 8'd0;
        res_r.status          <= is_access ? acc_status : STAT_OK;
        res_r.evicted         <= (state_nxt == S_SCAN);
        res_r.erased          <= 1'b0;
        res_r.end_of_transfer <= item_r.last_of_transfer;
      end
      S_READ: begin
        // a dirty hit serves the line, everything else the flash array (0xFF if never written)
        if (hit && line_dirty_r) begin
          res_r.read_data <= lb_q_r;
        end else begin
          res_r.read_data <= sec_fill ? fl_q_r : BLANK_BYTE;
        end
      end
      S_WBACK: begin
        if (cnt_r == '0) begin
          res_r.erased <= !blank_r;
        end
      end
      default: begin
      end
    endcase
    if (state_r == S_FIN && out_free) begin
      out_data_r <= res_r;
    end
  end

  // checks
  a_dirty_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
    line_dirty_r |-> line_valid_r)
    else $error("dirty line without a valid tag");

  a_accept_starts_check: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_CHECK))
    else $error("accepted transaction did not enter decode");

  a_erase_only_on_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!out_data_r.erased || out_data_r.evicted))
    else $error("erase flagged without a write-back");

  a_failed_is_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.status != STAT_OK) |->
      (!out_data_r.evicted && out_data_r.read_data == 8'd0))
    else $error("failed access touched the line or returned data");

  a_scan_full_line: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && state_nxt == S_WBACK) |-> (cnt_r == CNT_END))
    else $error("write-back started before the scan covered the line");

endmodule
